// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the page table walker.
// Every check is sampled on clk_i; the first form is gated off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define FLPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define FLPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/flpt_pkg.sv =====
// ----------------------------------------------------------------------------
// flpt_pkg
// Types and constants of the four level page table walker.
// ----------------------------------------------------------------------------
package flpt_pkg;

  localparam int unsigned VaddrW    = 48;
  localparam int unsigned PhysW     = 52;
  localparam int unsigned AddrW     = 64;
  localparam int unsigned DataW     = 64;
  localparam int unsigned RemainW   = 40;
  localparam int unsigned IndexW    = 9;
  localparam int unsigned LevelW    = 2;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned FrameLsb  = 12;
  localparam int unsigned FlagValid = 0;
  localparam int unsigned FlagPs    = 7;

  localparam logic [LevelW-1:0] LastLevel = 2'd3;

  typedef enum logic {
    KindXlate = 1'b0,
    KindResp  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    RkRead   = 2'd0,
    RkDone   = 2'd1,
    RkFault  = 2'd2,
    RkReject = 2'd3
  } rk_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRootTable  = 1'b0,
    CfgWindowBase = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    kind_e             kind;
    logic [VaddrW-1:0] virtual_address;
    logic [DataW-1:0]  read_data;
    logic              read_error;
  } req_t;

  typedef struct packed {
    rk_e                result_kind;
    logic [AddrW-1:0]   read_address;
    logic [PhysW-1:0]   phys_address;
    logic [RemainW-1:0] page_remaining;
  } rsp_t;

  typedef struct packed {
    logic [PhysW-1:0] root_table;
    logic [AddrW-1:0] window_base;
  } cfg_t;

  // Nine index bits of the virtual address for a level (level 0 at bit 39).
  function automatic logic [IndexW-1:0] level_index(logic [VaddrW-1:0] va,
                                                    logic [LevelW-1:0] lvl);
    logic [IndexW-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  // Mask of the page offset bits when the walk ends at a level.
  function automatic logic [PhysW-1:0] page_mask(logic [LevelW-1:0] lvl);
    logic [PhysW-1:0] m;
    case (lvl)
      2'd0:    m = {13'd0, {39{1'b1}}};
      2'd1:    m = {22'd0, {30{1'b1}}};
      2'd2:    m = {31'd0, {21{1'b1}}};
      default: m = {40'd0, {12{1'b1}}};
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/flpt_if.sv =====
// ----------------------------------------------------------------------------
// flpt_if
// Valid/ready channels of the page table walker: requests, results, config.
// ----------------------------------------------------------------------------
interface flpt_req_if;
  import flpt_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [VaddrW-1:0] virtual_address;
  logic [DataW-1:0]  read_data;
  logic              read_error;

  modport source (output valid, kind, virtual_address, read_data, read_error,
                  input ready);
  modport sink (input valid, kind, virtual_address, read_data, read_error,
                output ready);
endinterface

interface flpt_rsp_if;
  import flpt_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [AddrW-1:0]   read_address;
  logic [PhysW-1:0]   phys_address;
  logic [RemainW-1:0] page_remaining;

  modport source (output valid, result_kind, read_address, phys_address,
                  page_remaining, input ready);
  modport sink (input valid, result_kind, read_address, phys_address,
                page_remaining, output ready);
endinterface

interface flpt_cfg_if;
  import flpt_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/four_level_page_table_walker.sv =====
// Four level page table walker.
// req_i carries translate requests (kind 0, virtual_address) and memory read
// responses (kind 1, read_data, read_error). rsp_o gives one result per
// request: a read request with the entry address, a finished translation
// with the physical address and bytes left in the page, a fault, or a reject.
// cfg_i writes root_table (index 0) and window_base (index 1); it is always
// ready. The user must write it only while no request is in flight; the block
// does not enforce this. A request is held in an input register, evaluated
// against the walk state, and its result lands in an output register that
// drives rsp_o.valid; that move waits while a stalled result is held there.
// Throughput is one request per cycle while rsp_o is not stalled, set by that
// single evaluation step; the walk state is updated as each request moves to
// the output register, so back to back requests see each other's effect.
// When rsp_o is stalled the input register keeps one more request and then
// req_i.ready drops. Reset clears the walk state, the config registers and
// the valid flags of both pipeline registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Top level: input register, walk step, output register and config registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module four_level_page_table_walker (
  input  logic       clk_i,
  input  logic       rst_ni,
  flpt_req_if.sink   req_i,
  flpt_rsp_if.source rsp_o,
  flpt_cfg_if.sink   cfg_i
);
  import flpt_pkg::*;

  logic in_vld_q, in_vld_d;
  req_t in_q;
  logic out_vld_q, out_vld_d;
  rsp_t out_q;
  rsp_t step_res;
  cfg_t cfg;
  logic adv;
  logic req_fire;

  assign cfg_i.ready = 1'b1;

  flpt_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  assign adv         = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || adv;
  assign req_fire    = req_i.valid && req_i.ready;

  flpt_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (req_i.ready) begin
      in_vld_d = req_i.valid;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      in_q.kind            <= kind_e'(req_i.kind);
      in_q.virtual_address <= req_i.virtual_address;
      in_q.read_data       <= req_i.read_data;
      in_q.read_error      <= req_i.read_error;
    end
    if (adv) begin
      out_q <= step_res;
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.result_kind    = out_q.result_kind;
  assign rsp_o.read_address   = out_q.read_address;
  assign rsp_o.phys_address   = out_q.phys_address;
  assign rsp_o.page_remaining = out_q.page_remaining;

  `FLPT_ASSERT(a_held_when_blocked,
    (in_vld_q && !adv) |=> in_vld_q,
    "pending request dropped while the output was stalled")
  `FLPT_ASSERT(a_result_follows_step,
    adv |=> rsp_o.valid,
    "evaluated request produced no result")
  `FLPT_ASSERT(a_no_overwrite,
    (out_vld_q && !rsp_o.ready) |-> !adv,
    "stalled result overwritten by a new one")

endmodule

// ===== rtl/flpt_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// flpt_cfg_regs
// Root table and window base registers, written through the config channel.
// ----------------------------------------------------------------------------
module flpt_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [flpt_pkg::CfgIdxW-1:0] wr_idx_i,
  input  logic [flpt_pkg::DataW-1:0]  wr_data_i,
  output flpt_pkg::cfg_t              cfg_o
);
  import flpt_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_idx_i))
        CfgRootTable:  cfg_d.root_table  = wr_data_i[PhysW-1:0];
        CfgWindowBase: cfg_d.window_base = wr_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/flpt_step.sv =====
// ----------------------------------------------------------------------------
// flpt_step
// Walk state and the per-item decision: read request, done, fault or reject.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flpt_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  flpt_pkg::req_t item_i,
  input  flpt_pkg::cfg_t cfg_i,
  output flpt_pkg::rsp_t res_o
);
  import flpt_pkg::*;

  logic              active_q, active_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [VaddrW-1:0] vaddr_q, vaddr_d;

  logic [LevelW-1:0] next_level;
  logic [PhysW-1:0]  mask;
  logic [PhysW-1:0]  paddr;
  logic [RemainW-1:0] offset;
  logic              entry_ok;
  logic              leaf;

  // Entry address: the frame (bits 51..12) and the index times eight never
  // overlap, so they are merged and only the window base is added.
  function automatic logic [AddrW-1:0] entry_addr(logic [AddrW-1:0] base,
                                                  logic [PhysW-1:0] frame,
                                                  logic [IndexW-1:0] idx);
    logic [AddrW-1:0] off;
    off = {12'd0, frame[PhysW-1:FrameLsb], 12'd0} | {52'd0, idx, 3'd0};
    return base + off;
  endfunction

  assign next_level = level_q + 2'd1;
  assign mask       = page_mask(level_q);
  assign paddr      = (item_i.read_data[PhysW-1:0] & ~mask) | ({4'd0, vaddr_q} & mask);
  assign offset     = paddr[RemainW-1:0] & mask[RemainW-1:0];
  assign entry_ok   = !item_i.read_error && item_i.read_data[FlagValid];
  assign leaf       = item_i.read_data[FlagPs] || (level_q == LastLevel);

  always_comb begin
    active_d = active_q;
    level_d  = level_q;
    vaddr_d  = vaddr_q;
    res_o    = '0;
    if (item_i.kind == KindXlate) begin
      if (active_q) begin
        res_o.result_kind = RkReject;
      end else begin
        active_d           = 1'b1;
        level_d            = '0;
        vaddr_d            = item_i.virtual_address;
        res_o.result_kind  = RkRead;
        res_o.read_address = entry_addr(cfg_i.window_base, cfg_i.root_table,
                                        level_index(item_i.virtual_address, 2'd0));
      end
    end else if (!active_q) begin
      res_o.result_kind = RkReject;
    end else if (!entry_ok) begin
      active_d          = 1'b0;
      res_o.result_kind = RkFault;
    end else if (leaf) begin
      active_d             = 1'b0;
      res_o.result_kind    = RkDone;
      res_o.phys_address   = paddr;
      res_o.page_remaining = (mask[RemainW-1:0] + 40'd1) - offset;
    end else begin
      level_d            = next_level;
      res_o.result_kind  = RkRead;
      res_o.read_address = entry_addr(cfg_i.window_base, item_i.read_data[PhysW-1:0],
                                      level_index(vaddr_q, next_level));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      level_q  <= '0;
      vaddr_q  <= '0;
    end else if (fire_i) begin
      active_q <= active_d;
      level_q  <= level_d;
      vaddr_q  <= vaddr_d;
    end
  end

  `FLPT_ASSERT(a_done_has_room,
    (res_o.result_kind == RkDone) |-> (res_o.page_remaining != '0),
    "finished walk with zero bytes remaining")
  `FLPT_ASSERT(a_walk_starts_on_xlate,
    $rose(active_q) |-> $past(fire_i && item_i.kind == KindXlate),
    "walk became active without a translate request")
  `FLPT_ASSERT(a_level_moves_while_active,
    (level_q != $past(level_q)) |-> $past(fire_i) && ($past(active_q) || active_q),
    "walk level changed outside an accepted item of a walk")
  `FLPT_ASSERT_ALWAYS(a_addr_only_on_read,
    (res_o.result_kind != RkRead) |-> (res_o.read_address == '0),
    "read address driven on a result that is not a read request")

endmodule

// ===== tb/tb_four_level_page_table_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_level_page_table_walker
// Self-checking bench for the walker: drives translate requests and table
// entry responses, predicts each result from its own walk state and compares.
// ----------------------------------------------------------------------------
module tb_four_level_page_table_walker;
  import flpt_pkg::*;

  localparam logic [63:0] FrameMask = 64'h000F_FFFF_FFFF_F000;
  localparam int unsigned TopShift  = 39;

  logic clk_i;
  logic rst_ni;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  flpt_req_if req_if ();
  flpt_rsp_if rsp_if ();
  flpt_cfg_if cfg_if ();

  four_level_page_table_walker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Tracks the walk as the block should see it and keeps the results still owed.
  class walk_ledger;
    rsp_t              owed_results[$];
    int unsigned       mismatch_count;
    logic [PhysW-1:0]  root_table;
    logic [AddrW-1:0]  window_base;
    logic              walking;
    logic [LevelW-1:0] depth;
    logic [VaddrW-1:0] walk_va;

    function new();
      mismatch_count = 0;
      root_table     = '0;
      window_base    = '0;
      walking        = 1'b0;
      depth          = '0;
      walk_va        = '0;
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      $display("%0t MISMATCH %s", $realtime, what);
    endtask

    function void write_reg(cfg_idx_e idx, logic [DataW-1:0] value);
      case (idx)
        CfgRootTable:  root_table = value[PhysW-1:0];
        CfgWindowBase: window_base = value;
        default: ;
      endcase
    endfunction

    function logic [AddrW-1:0] entry_read_addr(logic [63:0] frame_src);
      int unsigned sh;
      logic [63:0] idx;
      sh  = TopShift - IndexW * int'(depth);
      idx = ({16'd0, walk_va} >> sh) & 64'h1FF;
      return window_base + (frame_src & FrameMask) + (idx << 3);
    endfunction

    function void take_request(req_t r);
      rsp_t        e;
      int unsigned sh;
      logic [63:0] low;
      logic [63:0] keep;
      logic [63:0] pa;
      logic [63:0] rem;
      e = '0;
      if (r.kind == KindXlate) begin
        if (walking) begin
          e.result_kind = RkReject;
        end else begin
          walk_va = r.virtual_address;
          depth   = '0;
          walking = 1'b1;
          e.result_kind  = RkRead;
          e.read_address = entry_read_addr({12'd0, root_table});
        end
      end else if (!walking) begin
        e.result_kind = RkReject;
      end else if (r.read_error || !r.read_data[FlagValid]) begin
        walking = 1'b0;
        e.result_kind = RkFault;
      end else if (r.read_data[FlagPs] || depth == LastLevel) begin
        // The walk ends here: the page spans every address bit below this level.
        sh   = TopShift - IndexW * int'(depth);
        low  = (64'd1 << sh) - 64'd1;
        keep = (64'd1 << PhysW) - (64'd1 << sh);
        pa   = (r.read_data & keep) | ({16'd0, walk_va} & low);
        rem  = (pa | low) + 64'd1 - pa;
        walking = 1'b0;
        e.result_kind    = RkDone;
        e.phys_address   = pa[PhysW-1:0];
        e.page_remaining = rem[RemainW-1:0];
      end else begin
        depth = depth + 2'd1;
        e.result_kind  = RkRead;
        e.read_address = entry_read_addr(r.read_data);
      end
      owed_results.push_back(e);
    endfunction

    task match_result(rsp_t got);
      rsp_t e;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result kind %0d with no request outstanding",
                                  got.result_kind));
        return;
      end
      e = owed_results.pop_front();
      if (got.result_kind !== e.result_kind || got.read_address !== e.read_address ||
          got.phys_address !== e.phys_address ||
          got.page_remaining !== e.page_remaining) begin
        report_mismatch($sformatf(
          "kind %0d/%0d raddr %h/%h paddr %h/%h remain %h/%h (got/exp)",
          got.result_kind, e.result_kind, got.read_address, e.read_address,
          got.phys_address, e.phys_address, got.page_remaining, e.page_remaining));
      end
    endtask
  endclass

  walk_ledger ledger = new();

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin
    #5_000_000;
    $display("** four_level_page_table_walker: FAILED **");
    $finish;
  end

  // Result side: sample at the edge, then pick the ready level for the next cycle.
  initial begin
    rsp_t got;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        got.result_kind    = rk_e'(rsp_if.result_kind);
        got.read_address   = rsp_if.read_address;
        got.phys_address   = rsp_if.phys_address;
        got.page_remaining = rsp_if.page_remaining;
        ledger.match_result(got);
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t xlate(logic [VaddrW-1:0] va);
    req_t r;
    r = '0;
    r.kind = KindXlate;
    r.virtual_address = va;
    return r;
  endfunction

  function automatic req_t entry(logic [DataW-1:0] value, logic err);
    req_t r;
    r = '0;
    r.kind = KindResp;
    r.read_data = value;
    r.read_error = err;
    return r;
  endfunction

  task automatic push_item(req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.kind            <= item.kind;
    req_if.virtual_address <= item.virtual_address;
    req_if.read_data       <= item.read_data;
    req_if.read_error      <= item.read_error;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    ledger.take_request(item);
  endtask

  task automatic write_regs(logic [DataW-1:0] root_val, logic [DataW-1:0] window_val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CfgRootTable;
    cfg_if.data  <= root_val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    ledger.write_reg(CfgRootTable, root_val);
    cfg_if.index <= CfgWindowBase;
    cfg_if.data  <= window_val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    ledger.write_reg(CfgWindowBase, window_val);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (ledger.owed_results.size() != 0) @(posedge clk_i);
  endtask

  // Mostly complete walks with random entries; the rest are stray requests,
  // abandoned walks, read errors and invalid entries.
  task automatic run_walks(int unsigned n);
    int unsigned sent;
    int unsigned lvl;
    int unsigned pick;
    logic [63:0] value;
    logic [63:0] va_word;
    bit          walk_over;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 8) begin
        value   = rand64();
        va_word = rand64();
        push_item('{kind: kind_e'(value[0]), virtual_address: va_word[VaddrW-1:0],
                    read_data: rand64(), read_error: value[1]});
        sent++;
      end else begin
        va_word = rand64();
        push_item(xlate(va_word[VaddrW-1:0]));
        sent++;
        lvl = 0;
        walk_over = 1'b0;
        while (!walk_over && sent < n) begin
          pick  = $urandom_range(99);
          value = rand64();
          if (pick < 3) begin
            va_word = rand64();
            push_item(xlate(va_word[VaddrW-1:0]));
          end else if (pick < 5) begin
            walk_over = 1'b1;
            continue;
          end else if (pick < 9) begin
            push_item(entry(value, 1'b1));
            walk_over = 1'b1;
          end else if (pick < 13) begin
            value[FlagValid] = 1'b0;
            push_item(entry(value, 1'b0));
            walk_over = 1'b1;
          end else begin
            value[FlagValid] = 1'b1;
            if (lvl < 3) value[FlagPs] = ($urandom_range(7) == 0);
            push_item(entry(value, 1'b0));
            walk_over = value[FlagPs] || lvl == 3;
            lvl++;
          end
          sent++;
        end
      end
    end
  endtask

  initial begin
    req_if.valid           <= 1'b0;
    req_if.kind            <= KindXlate;
    req_if.virtual_address <= '0;
    req_if.read_data       <= '0;
    req_if.read_error      <= 1'b0;
    cfg_if.valid           <= 1'b0;
    cfg_if.index           <= CfgRootTable;
    cfg_if.data            <= '0;
    rst_ni                 <= 1'b0;
    send_idle_pct = 9;
    recv_idle_pct = 51;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Root value carries junk above bit 51 and in the page offset.
    write_regs(64'hABC0_0012_3456_7FFF, 64'h0000_7F00_0000_0000);
    push_item(entry(64'h0000_0000_0000_1001, 1'b0));     // response with no walk
    push_item(xlate(48'h0));
    push_item(xlate(48'h1234_5678_9ABC));                 // request during a walk
    push_item(entry(64'h0000_0000_0000_2001, 1'b1));     // read error
    push_item(xlate(48'hFFFF_FFFF_FFFF));
    push_item(entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b0));     // large page at the top
    push_item(xlate(48'h8040_2010_0ABC));
    push_item(entry(64'hFFF0_0000_0000_0001, 1'b0));     // high bits, frame zero
    push_item(entry(64'h000F_FFFF_FFFF_F081, 1'b0));     // 1 GiB page
    push_item(xlate(48'h7FFF_FFFF_FFFF));
    push_item(entry(64'h8000_0000_0000_1003, 1'b0));
    push_item(entry(64'h000F_FFFF_FFFF_F001, 1'b0));
    push_item(entry(64'h0000_0000_0055_5001, 1'b0));
    push_item(entry(64'hFFFF_FFFF_FFFF_FF7F, 1'b0));     // last level, no size bit
    push_item(xlate(48'h0000_0000_0FFF));
    push_item(entry(64'hFFFF_FFFF_FFFF_FFFE, 1'b0));     // entry not valid
    push_item(xlate(48'h0123_4567_89AB));
    push_item(entry(64'h0000_0000_0000_0001, 1'b0));
    push_item(entry(64'h0000_0000_0000_0001, 1'b0));
    push_item(entry(64'h000A_BCDE_F012_3481, 1'b0));     // 2 MiB page
    push_item(entry(64'h0, 1'b1));                        // error with no walk
    push_item(xlate(48'h0));                              // leave a walk open

    for (int seg = 0; seg < 7; seg++) begin
      drain();
      if (seg == 2) begin
        send_idle_pct = 51;
        recv_idle_pct = 9;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0:       write_regs(64'd0, 64'd0);
        1:       write_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        3:       write_regs(rand64(), 64'hFFFF_FFFF_FFFF_F000);
        default: write_regs(rand64(), rand64());
      endcase
      run_walks(250);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (ledger.mismatch_count == 0) begin
      $display("** four_level_page_table_walker: PASSED **");
    end else begin
      $display("** four_level_page_table_walker: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/flpt_pkg.sv
rtl/flpt_if.sv
rtl/flpt_cfg_regs.sv
rtl/flpt_step.sv
rtl/four_level_page_table_walker.sv
tb/tb_four_level_page_table_walker.sv
